FILE: design/attention_sparse_mask_evaluator_top_macros.svh
// Assertion macros used by the checker file of the mask evaluator.
// Each one samples on clk and is disabled while arst_n is low.
`ifndef ATTENTION_SPARSE_MASK_EVALUATOR_TOP_MACROS_SVH
`define ATTENTION_SPARSE_MASK_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define ASME_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASME_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/asme_pkg.sv
package asme_pkg;

	localparam int COL_W    = 20;
	localparam int WORD_W   = 32;
	localparam int HIDX_W   = 4;
	localparam int CNT_W    = 5;
	localparam int FLAG_W   = 5;
	// 32 tile bits per bitmap word
	localparam int BIT_W    = 5;
	// wide enough for a hole index or hole count up to 127
	localparam int LANE_W   = 7;
	// column limit compare width, covers 2^24
	localparam int LIM_W    = 25;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	localparam int FLAG_TILE  = 0;
	localparam int FLAG_SKIP  = 1;
	localparam int FLAG_FINE  = 2;
	localparam int FLAG_ROW   = 3;
	localparam int FLAG_HOLES = 4;

	// Early verdicts of the first stage, carried down to the final merge.
	typedef struct packed {
		logic kill;      // column at or past MAX_COLUMNS: always kept
		logic early;     // tile limit or block skip hit
		logic fine_en;   // fine mask bit of the tile is set
		logic row_hit;   // row limit check hit
		logic holes_en;  // hole checks are present
	} pre_t;

endpackage

FILE: design/asme_if.sv
interface asme_req_if;
	import asme_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic [HIDX_W-1:0]        hole_index;
	logic signed [WORD_W-1:0] hole_start;
	logic signed [WORD_W-1:0] hole_length;
	logic [COL_W-1:0]         column;
	logic signed [WORD_W-1:0] tile_limit;
	logic [WORD_W-1:0]        compute_word;
	logic [WORD_W-1:0]        mask_word;
	logic signed [WORD_W-1:0] row_limit;
	logic [FLAG_W-1:0]        present_flags;

	modport source (output valid, mode, hole_index, hole_start, hole_length, column,
		tile_limit, compute_word, mask_word, row_limit, present_flags, input ready);
	modport sink (input valid, mode, hole_index, hole_start, hole_length, column,
		tile_limit, compute_word, mask_word, row_limit, present_flags, output ready);
endinterface

interface asme_rsp_if;
	logic valid;
	logic ready;
	logic masked;

	modport source (output valid, masked, input ready);
	modport sink (input valid, masked, output ready);
endinterface

interface asme_cfg_if;
	import asme_pkg::*;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] hole_count;

	modport source (output valid, hole_count, input ready);
	modport sink (input valid, hole_count, output ready);
endinterface

FILE: design/asme_front.sv
module asme_front import asme_pkg::*; #(
	parameter int TILE_COLUMNS = 128,
	parameter int MAX_COLUMNS  = 1048576
) (
	input  logic                     clk,
	input  logic                     load_en,
	input  logic                     mode,
	input  logic [HIDX_W-1:0]        hole_index,
	input  logic signed [WORD_W-1:0] hole_start,
	input  logic signed [WORD_W-1:0] hole_length,
	input  logic [COL_W-1:0]         column,
	input  logic signed [WORD_W-1:0] tile_limit,
	input  logic [WORD_W-1:0]        compute_word,
	input  logic [WORD_W-1:0]        mask_word,
	input  logic signed [WORD_W-1:0] row_limit,
	input  logic [FLAG_W-1:0]        present_flags,
	output logic                     mode_s1,
	output logic [HIDX_W-1:0]        hole_index_s1,
	output logic signed [WORD_W-1:0] hole_start_s1,
	output logic signed [WORD_W-1:0] hole_length_s1,
	output logic [COL_W-1:0]         column_s1,
	output pre_t                     pre_s1
);

	// Tile number by reciprocal multiply: exact for every COL_W-bit column.
	localparam int TILE_W  = $clog2(TILE_COLUMNS);
	localparam int SHIFT   = COL_W + TILE_W;
	localparam int RECIP_W = COL_W + 2;
	localparam int PROD_W  = COL_W + RECIP_W;
	localparam longint unsigned RECIP =
		((longint'(1) << SHIFT) + longint'(TILE_COLUMNS) - 1) / longint'(TILE_COLUMNS);
	localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
	localparam logic [LIM_W-1:0]   MAXCOL_C = LIM_W'(MAX_COLUMNS);

	logic [PROD_W-1:0]        prod;
	logic [BIT_W-1:0]         bitpos;
	logic signed [WORD_W-1:0] kx;
	pre_t                     pre_c;

	always_comb begin
		prod   = PROD_W'(column) * PROD_W'(RECIP_C);
		bitpos = prod[SHIFT +: BIT_W];
		kx     = $signed(WORD_W'(column));

		pre_c.kill     = LIM_W'(column) >= MAXCOL_C;
		pre_c.early    = (present_flags[FLAG_TILE] && (kx > tile_limit))
			|| (present_flags[FLAG_SKIP] && compute_word[bitpos]);
		pre_c.fine_en  = present_flags[FLAG_FINE] && mask_word[bitpos];
		pre_c.row_hit  = present_flags[FLAG_ROW] && (kx >= row_limit);
		pre_c.holes_en = present_flags[FLAG_HOLES];
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			mode_s1        <= mode;
			hole_index_s1  <= hole_index;
			hole_start_s1  <= hole_start;
			hole_length_s1 <= hole_length;
			column_s1      <= column;
			pre_s1         <= pre_c;
		end
	end

endmodule

FILE: design/asme_hole_bank.sv
module asme_hole_bank import asme_pkg::*; #(
	parameter int MAX_HOLES = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [HIDX_W-1:0]        wr_index,
	input  logic signed [WORD_W-1:0] wr_start,
	input  logic signed [WORD_W-1:0] wr_length,
	input  logic                     eval_en,
	input  logic [COL_W-1:0]         column,
	input  logic [CNT_W-1:0]         hole_count,
	output logic [MAX_HOLES-1:0]     hit_s2
);

	localparam logic [LANE_W-1:0] MAXH_C = LANE_W'(MAX_HOLES);

	logic signed [WORD_W-1:0] start_q [MAX_HOLES];
	logic signed [WORD_W-1:0] length_q [MAX_HOLES];
	logic [LANE_W-1:0]        n_c;
	logic [LANE_W-1:0]        idx_c;
	logic signed [WORD_W:0]   k_c;
	logic [MAX_HOLES-1:0]     hit_c;

	// Clamp the count to the table depth.
	assign n_c   = (LANE_W'(hole_count) > MAXH_C) ? MAXH_C : LANE_W'(hole_count);
	assign idx_c = LANE_W'(wr_index);
	assign k_c   = $signed((WORD_W + 1)'(column));

	for (genvar i = 0; i < MAX_HOLES; i++) begin : g_lane
		logic signed [WORD_W:0] lo_c;
		logic signed [WORD_W:0] hi_c;

		assign lo_c     = {start_q[i][WORD_W-1], start_q[i]};
		assign hi_c     = lo_c + {length_q[i][WORD_W-1], length_q[i]};
		assign hit_c[i] = (LANE_W'(i) < n_c) && (length_q[i] > 0)
			&& (k_c >= lo_c) && (k_c < hi_c);
	end

	// Loads write here in pipeline order, so every evaluation sees
	// exactly the loads that were accepted before it.
	always_ff @(posedge clk) begin
		for (int j = 0; j < MAX_HOLES; j++) begin
			if (wr_en && (idx_c == LANE_W'(j))) begin
				start_q[j]  <= wr_start;
				length_q[j] <= wr_length;
			end
		end
		if (eval_en) begin
			hit_s2 <= hit_c;
		end
	end

endmodule

FILE: design/attention_sparse_mask_evaluator_top.sv
// Attention sparse-mask evaluator. Each item on req is either a hole load
// (mode 0), which writes one (start, length) entry of a MAX_HOLES-deep hole
// table and returns nothing, or an evaluation (mode 1), which returns one
// masked bit on rsp for key column k. Evaluation masks when k is past the
// tile limit, when the block-skip bit of tile (k / TILE_COLUMNS) % 32 is set,
// or, with the fine-mask bit of that tile set, when k is at or past the row
// limit or inside any of the first hole_count holes with positive length;
// each check runs only with its presence flag set. Columns at or past
// MAX_COLUMNS are always kept. The block is a three-stage pipeline: stage 1
// finds the tile bit by a reciprocal multiply and does the limit and bitmap
// checks, stage 2 compares k against all hole entries in parallel lanes and
// is where loads write the table, stage 3 merges the verdicts into the
// output register. One item is taken per clock while req is ready; a result
// passes stages 1 and 2 and is offered on rsp from the output register.
// A stall on rsp holds the output register, items behind it still advance
// into empty stages, and req drops ready only once all three stages are
// full. Loads take effect in order with evaluations,
// so a load may be followed directly by an evaluation that uses it. A hole
// entry reads as garbage until it is first loaded. hole_count is written on
// cfg, which is always ready; write it only while no item is in flight.
module attention_sparse_mask_evaluator_top import asme_pkg::*; #(
	parameter int MAX_HOLES    = 16,
	parameter int TILE_COLUMNS = 128,
	parameter int MAX_COLUMNS  = 1048576
) (
	input  logic       clk,
	input  logic       arst_n,
	asme_req_if.sink   req,
	asme_rsp_if.source rsp,
	asme_cfg_if.sink   cfg
);

	// Stage valid bits and advance strobes.
	logic valid_s1, valid_s2, valid_s3;
	logic adv1, adv2, adv3;

	// Stage 1 contents.
	logic                     mode_s1;
	logic [HIDX_W-1:0]        hole_index_s1;
	logic signed [WORD_W-1:0] hole_start_s1;
	logic signed [WORD_W-1:0] hole_length_s1;
	logic [COL_W-1:0]         column_s1;
	pre_t                     pre_s1;

	// Stage 2 contents.
	pre_t                     pre_s2;
	logic [MAX_HOLES-1:0]     hit_s2;

	// Output register.
	logic                     masked_s3;

	logic [CNT_W-1:0]         hole_count_q;
	logic                     any_hole_c;
	logic                     masked_c;

	// A stage advances when it is empty or the one after it advances.
	assign adv3 = !valid_s3 || rsp.ready;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;

	assign req.ready = adv1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_count_q <= '0;
		end else if (cfg.valid) begin
			hole_count_q <= cfg.hole_count;
		end
	end

	// Stage 1: tile bit, limit checks, bitmap lookups.
	asme_front #(
		.TILE_COLUMNS (TILE_COLUMNS),
		.MAX_COLUMNS  (MAX_COLUMNS)
	) u_front (
		.clk            (clk),
		.load_en        (adv1 && req.valid),
		.mode           (req.mode),
		.hole_index     (req.hole_index),
		.hole_start     (req.hole_start),
		.hole_length    (req.hole_length),
		.column         (req.column),
		.tile_limit     (req.tile_limit),
		.compute_word   (req.compute_word),
		.mask_word      (req.mask_word),
		.row_limit      (req.row_limit),
		.present_flags  (req.present_flags),
		.mode_s1        (mode_s1),
		.hole_index_s1  (hole_index_s1),
		.hole_start_s1  (hole_start_s1),
		.hole_length_s1 (hole_length_s1),
		.column_s1      (column_s1),
		.pre_s1         (pre_s1)
	);

	// Stage 2: loads write the table, evaluations compare all lanes.
	asme_hole_bank #(
		.MAX_HOLES (MAX_HOLES)
	) u_hole_bank (
		.clk        (clk),
		.wr_en      (adv2 && valid_s1 && (mode_s1 == MODE_LOAD)),
		.wr_index   (hole_index_s1),
		.wr_start   (hole_start_s1),
		.wr_length  (hole_length_s1),
		.eval_en    (adv2 && valid_s1 && (mode_s1 == MODE_EVAL)),
		.column     (column_s1),
		.hole_count (hole_count_q),
		.hit_s2     (hit_s2)
	);

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			pre_s2 <= pre_s1;
		end
	end

	// Stage 3: merge the verdicts in check order.
	always_comb begin
		any_hole_c = |hit_s2;
		masked_c   = !pre_s2.kill && (pre_s2.early
			|| (pre_s2.fine_en && (pre_s2.row_hit || (pre_s2.holes_en && any_hole_c))));
	end

	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			masked_s3 <= masked_c;
		end
	end

	// Valid bits: loads drop out after stage 1, they make no result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= req.valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1 && (mode_s1 == MODE_EVAL);
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign rsp.valid  = valid_s3;
	assign rsp.masked = masked_s3;

endmodule

FILE: design/asme_checker.sv
`include "attention_sparse_mask_evaluator_top_macros.svh"

module asme_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic req_mode,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic rsp_masked
);

	// A pending result stays offered until its transfer.
	`ASME_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")

	// The offered bit does not change under a stall.
	`ASME_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_masked), "rsp changed")

	// The input side only stalls when the output side is stalled.
	`ASME_ASSERT_NOW(a_req_stall, !req_ready, rsp_valid && !rsp_ready, "req stalled freely")

	// With the output draining, an evaluation shows up on rsp after stages 1, 2 and 3.
	`ASME_ASSERT_NEXT(a_eval_lat, req_valid && req_ready && req_mode ##1 rsp_ready ##1 rsp_ready, rsp_valid, "result late")

endmodule

bind attention_sparse_mask_evaluator_top asme_checker u_asme_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_mode   (req.mode),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_masked (rsp.masked)
);

FILE: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import asme_pkg::*;

	localparam int MAX_HOLES      = 16;
	localparam int TILE_COLS      = 128;
	localparam int COL_MAX        = (1 << COL_W) - 1;
	localparam int WORD_MAX       = 32'sh7FFF_FFFF;
	localparam int WORD_MIN       = 32'sh8000_0000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int DRAIN_EVERY    = 100;
	localparam int RAND_PER_PHASE = 80;
	localparam int N_PHASES       = 6;
	localparam int LIMIT_NS       = 2_000_000;

	// presence flag masks
	localparam bit [FLAG_W-1:0] F_TILE  = 5'd1 << FLAG_TILE;
	localparam bit [FLAG_W-1:0] F_SKIP  = 5'd1 << FLAG_SKIP;
	localparam bit [FLAG_W-1:0] F_FINE  = 5'd1 << FLAG_FINE;
	localparam bit [FLAG_W-1:0] F_ROW   = 5'd1 << FLAG_ROW;
	localparam bit [FLAG_W-1:0] F_HOLES = 5'd1 << FLAG_HOLES;
	localparam bit [FLAG_W-1:0] F_ALL   = F_TILE | F_SKIP | F_FINE | F_ROW | F_HOLES;

	// one request as the sender sees it
	typedef struct {
		bit                mode;
		bit [HIDX_W-1:0]   hole_index;
		int                hole_start;
		int                hole_length;
		bit [COL_W-1:0]    column;
		int                tile_limit;
		bit [WORD_W-1:0]   compute_word;
		bit [WORD_W-1:0]   mask_word;
		int                row_limit;
		bit [FLAG_W-1:0]   present_flags;
	} mask_req_t;

	typedef struct {
		bit             masked;
		bit [COL_W-1:0] column;
		int             seq;
	} mask_expect_t;

	logic clk;
	logic arst_n;

	asme_req_if req_bus ();
	asme_rsp_if rsp_bus ();
	asme_cfg_if cfg_bus ();

	attention_sparse_mask_evaluator_top #(
		.MAX_HOLES   (MAX_HOLES),
		.TILE_COLUMNS(TILE_COLS),
		.MAX_COLUMNS (COL_MAX + 1)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_bus),
		.rsp   (rsp_bus),
		.cfg   (cfg_bus)
	);

	// Requests waiting to be driven, and mask bits waiting to come back.
	mask_req_t    req_stream[$];
	mask_expect_t masked_expect_q[$];

	// Predictor state: the hole table and hole_count as the block should hold them.
	int hole_first_tab [MAX_HOLES];
	int hole_width_tab [MAX_HOLES];
	int hole_count_reg;

	// Generator shadow of the table, used to steer stimulus and to avoid reading
	// entries that no load has written yet.
	int              gen_first [MAX_HOLES];
	int              gen_width [MAX_HOLES];
	bit [MAX_HOLES-1:0] gen_written;
	int              gen_count;

	int send_idle_pct;
	int recv_stall_pct;
	bit drain_hold;

	int accepted_total;
	int loads_done;
	int evals_done;
	int results_due;
	int results_seen;
	int masked_seen;
	int kept_seen;
	int mismatch_count;
	int settings_used;

	int phase_count [N_PHASES] = '{16, 31, 0, 7, 1, 12};
	int phase_send  [N_PHASES] = '{0, 88, 0, 26, 0, 26};
	int phase_recv  [N_PHASES] = '{0, 0, 88, 26, 0, 26};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#LIMIT_NS;
		$display("** attention_sparse_mask_evaluator_top: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// Work out the mask bit of one evaluation from the current table and
	// hole_count. The checks run in priority order and the first hit wins.
	function automatic bit mask_verdict(mask_req_t it);
		longint k;
		int     tile;
		int     n;
		bit     hit;
		k    = longint'(it.column);
		tile = (it.column / TILE_COLS) % 32;
		hit  = 1'b0;
		if (it.present_flags[FLAG_TILE] && k > longint'(it.tile_limit))
			hit = 1'b1;
		if (!hit && it.present_flags[FLAG_SKIP] && it.compute_word[tile])
			hit = 1'b1;
		if (!hit && it.present_flags[FLAG_FINE] && it.mask_word[tile]) begin
			if (it.present_flags[FLAG_ROW] && k >= longint'(it.row_limit))
				hit = 1'b1;
			if (!hit && it.present_flags[FLAG_HOLES]) begin
				n = (hole_count_reg > MAX_HOLES) ? MAX_HOLES : hole_count_reg;
				// hole end is start + length in wide arithmetic, so no wrap
				for (int i = 0; i < n; i++) begin
					if (hole_width_tab[i] > 0 && longint'(hole_first_tab[i]) <= k &&
							k < longint'(hole_first_tab[i]) + longint'(hole_width_tab[i]))
						hit = 1'b1;
				end
			end
		end
		return hit;
	endfunction

	// Apply one accepted request: write the table, or queue the expected bit.
	function automatic void retire_request(mask_req_t it);
		mask_expect_t e;
		if (it.mode == MODE_LOAD) begin
			hole_first_tab[it.hole_index] = it.hole_start;
			hole_width_tab[it.hole_index] = it.hole_length;
			loads_done++;
		end else begin
			e.masked = mask_verdict(it);
			e.column = it.column;
			e.seq    = evals_done;
			masked_expect_q.push_back(e);
			evals_done++;
			results_due++;
		end
	endfunction

	function automatic void push_load(input int idx, input int start, input int len);
		mask_req_t it;
		// fill the fields a load ignores with junk
		it.mode          = MODE_LOAD;
		it.hole_index    = idx[HIDX_W-1:0];
		it.hole_start    = start;
		it.hole_length   = len;
		it.column        = COL_W'($urandom);
		it.tile_limit    = $urandom;
		it.compute_word  = $urandom;
		it.mask_word     = $urandom;
		it.row_limit     = $urandom;
		it.present_flags = FLAG_W'($urandom);
		gen_first[it.hole_index]   = start;
		gen_width[it.hole_index]   = len;
		gen_written[it.hole_index] = 1'b1;
		req_stream.push_back(it);
	endfunction

	function automatic void push_eval(input int col, input int tlim, input bit [WORD_W-1:0] cw,
			input bit [WORD_W-1:0] mw, input int rlim, input bit [FLAG_W-1:0] flags);
		mask_req_t it;
		int        n;
		it.mode          = MODE_EVAL;
		it.hole_index    = HIDX_W'($urandom);
		it.hole_start    = $urandom;
		it.hole_length   = $urandom;
		it.column        = col[COL_W-1:0];
		it.tile_limit    = tlim;
		it.compute_word  = cw;
		it.mask_word     = mw;
		it.row_limit     = rlim;
		it.present_flags = flags;
		// drop the hole check while any counted entry is still unwritten
		n = (gen_count > MAX_HOLES) ? MAX_HOLES : gen_count;
		for (int i = 0; i < n; i++)
			if (!gen_written[i])
				it.present_flags[FLAG_HOLES] = 1'b0;
		req_stream.push_back(it);
	endfunction

	// Random mix: mostly evaluations aimed at the limits and the loaded holes,
	// some loads, and a share of pure noise.
	task automatic queue_random_items(input int count);
		int     slot;
		int     col;
		int     tile;
		int     tlim;
		int     rlim;
		longint reach;
		bit [WORD_W-1:0] cw;
		bit [WORD_W-1:0] mw;
		bit [FLAG_W-1:0] flags;
		repeat (count) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(4))
					0, 1, 2: push_load($urandom_range(MAX_HOLES - 1),
						int'($urandom_range(COL_MAX)) - int'($urandom_range(16)),
						1 + int'($urandom_range(2047)));
					3: push_load($urandom_range(MAX_HOLES - 1), $urandom,
						($urandom_range(1) == 0) ? 0 : -1 - int'($urandom_range(WORD_MAX - 1)));
					default: push_load($urandom_range(MAX_HOLES - 1), $urandom, $urandom);
				endcase
			end else begin
				slot = $urandom_range(MAX_HOLES - 1);
				if ($urandom_range(1) == 1 && gen_written[slot] && gen_width[slot] > 0 &&
						gen_first[slot] >= 0 && gen_first[slot] <= COL_MAX) begin
					reach = longint'(gen_first[slot]) - 1 + longint'($urandom_range(
						(gen_width[slot] > 4096) ? 4096 : gen_width[slot] + 1));
					col = (reach > COL_MAX) ? COL_MAX : ((reach < 0) ? 0 : int'(reach));
				end else begin
					col = $urandom_range(COL_MAX);
				end
				tile = (col / TILE_COLS) % 32;
				if ($urandom_range(4) == 0) begin
					push_eval(col, $urandom, $urandom, $urandom, $urandom,
						FLAG_W'($urandom_range(31)));
				end else begin
					case ($urandom_range(3))
						0: tlim = $urandom;
						1: tlim = col - 1 - int'($urandom_range(3));
						default: tlim = col + int'($urandom_range(64));
					endcase
					cw = $urandom;
					if ($urandom_range(3) != 0)
						cw[tile] = 1'b0;
					mw = $urandom;
					if ($urandom_range(3) != 0)
						mw[tile] = 1'b1;
					case ($urandom_range(3))
						0: rlim = $urandom;
						1: rlim = col - int'($urandom_range(2));
						default: rlim = col + 1 + int'($urandom_range(64));
					endcase
					flags = FLAG_W'($urandom_range(31));
					if ($urandom_range(9) < 6)
						flags = flags | F_FINE | F_HOLES;
					push_eval(col, tlim, cw, mw, rlim, flags);
				end
			end
		end
	endtask

	// Wait until the sender is empty and every expected bit has arrived, then
	// let trailing loads clear the pipeline.
	task automatic wait_for_drain();
		do @(negedge clk);
		while (req_stream.size() != 0 || req_bus.valid || masked_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_hole_count(input int value);
		@(posedge clk);
		gen_count = value;
		cfg_bus.valid      <= 1'b1;
		cfg_bus.hole_count <= value[CNT_W-1:0];
		do @(posedge clk);
		while (!cfg_bus.ready);
		hole_count_reg = value;
		settings_used++;
		cfg_bus.valid <= 1'b0;
	endtask

	// Request driver. Retire the request at each transfer, hold valid while the
	// block stalls, and otherwise decide per cycle whether to offer the next one.
	// Every DRAIN_EVERY transfers, pause until all outstanding bits are back.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				retire_request(req_stream.pop_front());
				accepted_total++;
				if (accepted_total % DRAIN_EVERY == 0)
					drain_hold = 1'b1;
			end
			// results_seen is updated by the monitor with a nonblocking write
			if (drain_hold && results_seen == results_due)
				drain_hold = 1'b0;
			if (!(req_bus.valid && !req_bus.ready)) begin
				if (req_stream.size() != 0 && !drain_hold &&
						$urandom_range(99) >= send_idle_pct) begin
					req_bus.valid         <= 1'b1;
					req_bus.mode          <= req_stream[0].mode;
					req_bus.hole_index    <= req_stream[0].hole_index;
					req_bus.hole_start    <= req_stream[0].hole_start;
					req_bus.hole_length   <= req_stream[0].hole_length;
					req_bus.column        <= req_stream[0].column;
					req_bus.tile_limit    <= req_stream[0].tile_limit;
					req_bus.compute_word  <= req_stream[0].compute_word;
					req_bus.mask_word     <= req_stream[0].mask_word;
					req_bus.row_limit     <= req_stream[0].row_limit;
					req_bus.present_flags <= req_stream[0].present_flags;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Compare each transfer with the oldest expected bit and
	// stall ready at the phase's rate.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (masked_expect_q.size() == 0) begin
					report_mismatch($sformatf("result masked=%b with nothing expected",
						rsp_bus.masked));
				end else begin
					if (rsp_bus.masked !== masked_expect_q[0].masked)
						report_mismatch($sformatf("eval #%0d column %0d: masked %b, expected %b",
							masked_expect_q[0].seq, masked_expect_q[0].column,
							rsp_bus.masked, masked_expect_q[0].masked));
					void'(masked_expect_q.pop_front());
				end
				if (rsp_bus.masked === 1'b1)
					masked_seen++;
				else
					kept_seen++;
				results_seen <= results_seen + 1;
			end
			rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		// Drive every input to a known value before the first edge.
		arst_n                = 1'b0;
		req_bus.valid         = 1'b0;
		req_bus.mode          = MODE_LOAD;
		req_bus.hole_index    = '0;
		req_bus.hole_start    = '0;
		req_bus.hole_length   = '0;
		req_bus.column        = '0;
		req_bus.tile_limit    = '0;
		req_bus.compute_word  = '0;
		req_bus.mask_word     = '0;
		req_bus.row_limit     = '0;
		req_bus.present_flags = '0;
		rsp_bus.ready         = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.hole_count    = '0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;
		hole_count_reg        = 0;
		gen_count             = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed, no holes counted: load a few edge-case holes, then walk
		// the limit and bitmap checks.
		write_hole_count(0);
		@(negedge clk);
		push_load(0, 100, 20);
		push_load(15, WORD_MIN, WORD_MAX);       // end just below zero
		push_load(1, WORD_MAX, WORD_MAX);        // end needs the 33rd bit
		push_load(2, 300, 0);                    // zero length: unused
		push_load(3, 400, WORD_MIN);             // negative length: unused
		push_eval(0, 0, '0, '0, 0, '0);
		push_eval(COL_MAX, WORD_MAX, '0, '1, WORD_MAX, F_ALL);
		push_eval(5, 4, '0, '0, 0, F_TILE);
		push_eval(5, WORD_MIN, '0, '0, 0, F_TILE);
		push_eval(5, 5, '0, '0, 0, F_TILE);
		push_eval(3 * TILE_COLS, WORD_MAX, 32'h8, '0, 0, F_SKIP);
		push_eval(35 * TILE_COLS, WORD_MAX, 32'h8, '0, 0, F_SKIP);   // tile index wraps
		push_eval(3 * TILE_COLS, WORD_MAX, ~32'h8, '0, 0, F_SKIP);
		push_eval(1000, 0, '0, 32'h80, 1000, F_FINE | F_ROW);
		push_eval(1000, 0, '0, 32'h80, 1001, F_FINE | F_ROW);
		push_eval(1000, 0, '0, ~32'h80, 1000, F_FINE | F_ROW);
		push_eval(1000, 0, '0, 32'h80, WORD_MIN, F_FINE | F_ROW);
		push_eval(1000, 0, '0, '1, 0, F_ROW);
		wait_for_drain();

		// Directed, first four holes counted: hit and miss the hole edges.
		write_hole_count(4);
		@(negedge clk);
		push_eval(100, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(119, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(120, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(99, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(300, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(400, 0, '0, '1, 0, F_FINE | F_HOLES);
		push_eval(COL_MAX, 0, '0, '1, 0, F_FINE | F_HOLES);
		wait_for_drain();

		// Random phases: each sets a table size (extremes included) and an
		// idle pattern on the two sides.
		for (int p = 0; p < N_PHASES; p++) begin
			write_hole_count(phase_count[p]);
			@(negedge clk);
			send_idle_pct  = phase_send[p];
			recv_stall_pct = phase_recv[p];
			queue_random_items(RAND_PER_PHASE);
			wait_for_drain();
		end

		$display("Checked %0d evaluations (%0d masked, %0d kept) against %0d hole loads.",
			evals_done, masked_seen, kept_seen, loads_done);
		$display("Used %0d hole_count settings, with idle sender, stalled receiver and both.",
			settings_used);
		if (mismatch_count == 0)
			$display("** attention_sparse_mask_evaluator_top: PASSED **");
		else
			$display("** attention_sparse_mask_evaluator_top: FAILED **");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/asme_pkg.sv
design/asme_if.sv
design/asme_front.sv
design/asme_hole_bank.sv
design/attention_sparse_mask_evaluator_top.sv
design/asme_checker.sv
verif/tb_top.sv
